/* sv/srsw_pkg.sv */
// Shared types and constants of the selective-repeat sender window.
package srsw_pkg;

  localparam int SEQ_FIELD_W     = 4;
  localparam int PAYLOAD_FIELD_W = 64;
  localparam int CMD_W           = 2;
  localparam int CFG_W           = 5;
  localparam int CFG_IDX_W       = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_MODULUS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT = 1'd1;

  localparam logic [CFG_W-1:0] SEQ_MODULUS_RST  = 5'd8;
  localparam logic [CFG_W-1:0] WINDOW_LIMIT_RST = 5'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } command_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd_load;
    logic scan_step;
    logic out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_read;
    logic need_scan;
    logic scan_done;
  } dp_status_t;

  typedef struct packed {
    logic                       accepted;
    logic                       tx_valid;
    logic [SEQ_FIELD_W-1:0]     tx_seq;
    logic [PAYLOAD_FIELD_W-1:0] tx_payload;
    logic                       timer_start;
    logic                       timer_stop;
    logic                       ack_taken;
    logic                       unknown_timeout;
    logic [SEQ_FIELD_W-1:0]     window_base;
    logic [SEQ_FIELD_W-1:0]     next_seq;
    logic                       window_full;
  } result_t;

endpackage

/* sv/srsw_if.sv */
// Channel interfaces for command items and result items.
interface srsw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [srsw_pkg::CMD_W-1:0]           command;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]     seq_number;
  logic                                 checksum_ok;
  logic [srsw_pkg::PAYLOAD_FIELD_W-1:0] payload_word;

  modport source(output valid, command, seq_number, checksum_ok, payload_word,
                 input ready);
  modport sink(input valid, command, seq_number, checksum_ok, payload_word,
               output ready);
endinterface

interface srsw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 accepted;
  logic                                 tx_valid;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]     tx_seq;
  logic [srsw_pkg::PAYLOAD_FIELD_W-1:0] tx_payload;
  logic                                 timer_start;
  logic                                 timer_stop;
  logic                                 ack_taken;
  logic                                 unknown_timeout;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]     window_base;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]     next_seq;
  logic                                 window_full;

  modport source(output valid, accepted, tx_valid, tx_seq, tx_payload, timer_start,
                 timer_stop, ack_taken, unknown_timeout, window_base, next_seq,
                 window_full, input ready);
  modport sink(input valid, accepted, tx_valid, tx_seq, tx_payload, timer_start,
               timer_stop, ack_taken, unknown_timeout, window_base, next_seq,
               window_full, output ready);
endinterface

/* sv/srsw_dp.sv */
// Datapath: configuration, window state, payload memory, base scan and result register.
module srsw_dp #(
  parameter int SEQ_SPACE    = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [srsw_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic [srsw_pkg::CMD_W-1:0]           command,
  input  logic [srsw_pkg::SEQ_FIELD_W-1:0]     seq_number,
  input  logic                                 checksum_ok,
  input  logic [srsw_pkg::PAYLOAD_FIELD_W-1:0] payload_word,
  input  srsw_pkg::dp_cmd_t                    cmd,
  output srsw_pkg::dp_status_t                 status,
  output srsw_pkg::result_t                    result
);

  localparam int SEQ_W  = $clog2(SEQ_SPACE);
  localparam int CNT_W  = $clog2(SEQ_SPACE + 1);
  localparam int CMP_W  = (CNT_W > srsw_pkg::CFG_W) ? CNT_W : srsw_pkg::CFG_W;
  localparam int SF_W   = srsw_pkg::SEQ_FIELD_W;
  localparam int PO_W   = srsw_pkg::PAYLOAD_FIELD_W;

  logic [srsw_pkg::CFG_W-1:0] cfg_mod_r, cfg_lim_r;

  logic [SEQ_SPACE-1:0] bits_r, bits_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [SEQ_W-1:0]     next_r, next_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SEQ_W-1:0]     scan_p_r, scan_p_nxt;
  logic [CNT_W-1:0]     scan_i_r, scan_i_nxt;

  logic [srsw_pkg::CMD_W-1:0] cmd_r;
  logic [SF_W-1:0]            sn_r;
  logic                       ck_r;
  logic [PAYLOAD_BITS-1:0]    pw_r;

  logic [PAYLOAD_BITS-1:0] mem [SEQ_SPACE];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic                    mem_we;

  srsw_pkg::result_t res_r, res_nxt;
  srsw_pkg::result_t out_r, out_nxt;

  srsw_pkg::command_t op;
  logic [CMP_W-1:0]   mod_ext, lim_ext, mod_cl;
  logic [CNT_W-1:0]   eff_mod, eff_lim;
  logic [SEQ_W-1:0]   sn_idx;
  logic               sn_live, send_ok, ack_ok;
  logic [SEQ_W-1:0]   scan_p_adv;
  logic               scan_hit, scan_last;

  function automatic logic [SEQ_W-1:0] seq_adv(input logic [SEQ_W-1:0] s,
                                               input logic [CNT_W-1:0] m);
    logic [SEQ_W:0] t;
    t = {1'b0, s} + 1'b1;
    if (32'(t) >= 32'(m)) begin
      return '0;
    end
    return SEQ_W'(t);
  endfunction

  // Clamp the configured modulus and window limit
  always_comb begin
    mod_ext = CMP_W'(cfg_mod_r);
    lim_ext = CMP_W'(cfg_lim_r);
    if (mod_ext < CMP_W'(2)) begin
      mod_cl = CMP_W'(2);
    end else if (32'(mod_ext) > SEQ_SPACE) begin
      mod_cl = CMP_W'(SEQ_SPACE);
    end else begin
      mod_cl = mod_ext;
    end
    eff_mod = CNT_W'(mod_cl);
    if (lim_ext == '0) begin
      eff_lim = CNT_W'(1);
    end else if (lim_ext > mod_cl) begin
      eff_lim = eff_mod;
    end else begin
      eff_lim = CNT_W'(lim_ext);
    end
  end

  assign op      = srsw_pkg::command_t'(cmd_r);
  assign sn_idx  = SEQ_W'(sn_r);
  assign sn_live = (32'(sn_r) < SEQ_SPACE) && bits_r[sn_idx];
  assign send_ok = (count_r < eff_lim) && !bits_r[next_r];
  assign ack_ok  = ck_r && sn_live;

  assign scan_p_adv = seq_adv(scan_p_r, eff_mod);
  assign scan_hit   = (scan_p_adv == next_r) || bits_r[scan_p_adv];
  assign scan_last  = (scan_i_r == CNT_W'(eff_mod - 1'b1));

  assign status.need_read = (op == srsw_pkg::CMD_TIMEOUT) && sn_live;
  assign status.need_scan = (op == srsw_pkg::CMD_ACK) && ack_ok && (sn_idx == base_r);
  assign status.scan_done = scan_hit || scan_last;

  always_comb begin
    bits_nxt   = bits_r;
    base_nxt   = base_r;
    next_nxt   = next_r;
    count_nxt  = count_r;
    scan_p_nxt = scan_p_r;
    scan_i_nxt = scan_i_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    mem_we     = 1'b0;

    if (cmd.exec) begin
      res_nxt = '0;
      case (op)
        srsw_pkg::CMD_SEND: begin
          if (send_ok) begin
            mem_we               = 1'b1;
            bits_nxt[next_r]     = 1'b1;
            count_nxt            = count_r + 1'b1;
            next_nxt             = seq_adv(next_r, eff_mod);
            res_nxt.accepted     = 1'b1;
            res_nxt.tx_valid     = 1'b1;
            res_nxt.tx_seq       = SF_W'(next_r);
            res_nxt.tx_payload   = PO_W'(pw_r);
            res_nxt.timer_start  = 1'b1;
          end
        end
        srsw_pkg::CMD_ACK: begin
          if (ack_ok) begin
            bits_nxt[sn_idx]   = 1'b0;
            count_nxt          = count_r - 1'b1;
            res_nxt.ack_taken  = 1'b1;
            res_nxt.timer_stop = 1'b1;
            res_nxt.tx_seq     = sn_r;
            scan_p_nxt         = base_r;
            scan_i_nxt         = '0;
          end
        end
        srsw_pkg::CMD_TIMEOUT: begin
          if (sn_live) begin
            res_nxt.tx_valid    = 1'b1;
            res_nxt.tx_seq      = sn_r;
            res_nxt.timer_start = 1'b1;
          end else begin
            res_nxt.unknown_timeout = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.rd_load) begin
      res_nxt.tx_payload = PO_W'(rd_data_r);
    end

    // One entry per cycle; stop on an outstanding entry, on the next number or at the last entry
    if (cmd.scan_step) begin
      if (scan_hit) begin
        base_nxt = scan_p_adv;
      end else if (scan_last) begin
        base_nxt = next_r;
      end else begin
        scan_p_nxt = scan_p_adv;
        scan_i_nxt = scan_i_r + 1'b1;
      end
    end

    if (cmd.out_load) begin
      out_nxt             = res_r;
      out_nxt.window_base = SF_W'(base_r);
      out_nxt.next_seq    = SF_W'(next_r);
      out_nxt.window_full = (count_r >= eff_lim);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mod_r <= srsw_pkg::SEQ_MODULUS_RST;
      cfg_lim_r <= srsw_pkg::WINDOW_LIMIT_RST;
      bits_r    <= '0;
      base_r    <= '0;
      next_r    <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srsw_pkg::REG_SEQ_MODULUS:  cfg_mod_r <= cfg_wdata;
          srsw_pkg::REG_WINDOW_LIMIT: cfg_lim_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      bits_r  <= bits_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= command;
      sn_r  <= seq_number;
      ck_r  <= checksum_ok;
      pw_r  <= payload_word[PAYLOAD_BITS-1:0];
    end
    scan_p_r <= scan_p_nxt;
    scan_i_r <= scan_i_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[next_r] <= pw_r;
    end
    rd_data_r <= mem[sn_idx];
  end

  assign result = out_r;

  a_count_tracks_bits: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(bits_r) == 32'(count_r))
    else $error("outstanding count disagrees with outstanding entries");

  a_send_marks_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && op == srsw_pkg::CMD_SEND && send_ok)
      |=> bits_r[$past(next_r)] && (count_r == $past(count_r) + 1'b1))
    else $error("accepted send did not mark its entry");

  a_scan_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && scan_hit) |=> (base_r == next_r) || bits_r[base_r])
    else $error("base moved to an entry that is neither outstanding nor next");

endmodule

/* sv/srsw_ctrl.sv */
// Controller: sequences capture, execution, payload read, base scan and result hand-off.
module srsw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  srsw_pkg::dp_status_t status,
  output srsw_pkg::dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_READ = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.need_read) begin
          state_nxt = S_READ;
        end else if (status.need_scan) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd_load = 1'b1;
        state_nxt   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && !out_ready) |=> state_r == S_DONE)
    else $error("result handed off while the output register was occupied");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r && state_r == S_IDLE)
    else $error("result load did not raise out valid");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("controller state is not one-hot");

endmodule

/* sv/selective_repeat_sender_window_unit.sv */
// Top level of the selective-repeat ARQ sender window.
//
//  channel  | direction | handshake          | content
//  ---------+-----------+--------------------+------------------------------------------
//  in_ch    | in        | valid/ready        | command, seq_number, checksum_ok, payload
//  out_ch   | out       | valid/ready        | tx and timer actions, base, next, full
//  cfg_*    | in        | cfg_we, no wait    | 0 seq_modulus, 1 window_limit
//
// An item is captured, executed and loaded into the output register (send, plain
// ack, unknown timeout); a good timeout adds a registered payload memory read, and
// an ack of the base adds the base scan, which checks one entry a cycle.
// One item is in work at a time; the next item is accepted as soon as the
// result sits in the output register, even while that result is stalled.
// Reset (rst_n low, synchronous) clears the window, base, next number and
// count and restores seq_modulus 8 and window_limit 4; payload memory is not cleared.
module selective_repeat_sender_window_unit #(
  parameter int SEQ_SPACE    = 16,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  srsw_in_if.sink                        in_ch,
  srsw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_wdata
);

  srsw_pkg::dp_cmd_t    dp_cmd;
  srsw_pkg::dp_status_t dp_status;
  srsw_pkg::result_t    result;

  // Sequencing: one item at a time, output register decoupled
  srsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Window state, payload memory and result register
  srsw_dp #(
    .SEQ_SPACE    (SEQ_SPACE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .command      (in_ch.command),
    .seq_number   (in_ch.seq_number),
    .checksum_ok  (in_ch.checksum_ok),
    .payload_word (in_ch.payload_word),
    .cmd          (dp_cmd),
    .status       (dp_status),
    .result       (result)
  );

  // Drive the result channel from the output register
  assign out_ch.accepted        = result.accepted;
  assign out_ch.tx_valid        = result.tx_valid;
  assign out_ch.tx_seq          = result.tx_seq;
  assign out_ch.tx_payload      = result.tx_payload;
  assign out_ch.timer_start     = result.timer_start;
  assign out_ch.timer_stop      = result.timer_stop;
  assign out_ch.ack_taken       = result.ack_taken;
  assign out_ch.unknown_timeout = result.unknown_timeout;
  assign out_ch.window_base     = result.window_base;
  assign out_ch.next_seq        = result.next_seq;
  assign out_ch.window_full     = result.window_full;

endmodule
